// ===== hw/rtl/irbh_pkg.sv =====
// ---------------------------------------------------------------------------
// irbh_pkg - shared constants for the IR beam-block detector
// Field widths, register map codes and the constants of the divide-by-100
// reciprocal used by the shared multiplier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package irbh_pkg;

  localparam int NUM_IR       = 6;
  localparam int CHANNELS_DEF = 6;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 12;
  localparam int TRIG_W   = 8;
  localparam int TRIGS_W  = NUM_IR * TRIG_W;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int REG_W  = 3;

  localparam logic [REG_W-1:0] REG_TRIGGER = REG_W'(NUM_IR);

  // floor(x / 100) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2^20
  localparam int MUL_A_W   = 20;
  localparam int MUL_B_W   = 21;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_SHIFT = 27;
  localparam int THR_W     = PROD_W - DIV_SHIFT;
  localparam int CMP_W     = THR_W + 1;

  localparam logic [MUL_B_W-1:0] DIV_RECIP    = MUL_B_W'(1342178);
  localparam logic [MUL_B_W-1:0] HOLD_PERCENT = MUL_B_W'(90);

endpackage

// ===== hw/rtl/ir_beam_block_hysteresis.sv =====
// ---------------------------------------------------------------------------
// ir_beam_block_hysteresis - per-channel IR beam-block detector
// Judges one ADC sample against its channel's baseline and trigger percent,
// with a lower release threshold once the channel is blocked.
// ---------------------------------------------------------------------------
// Usage:
//   Sample channel (channel, sample) and result channel (channel_out,
//   blocked, blocked_map) each transfer when valid is high and stall low.
//   Baselines and the packed trigger percents are written over the APB
//   port at byte address 8*i; write them only while no sample is in flight.
//   Each sample runs through one shared 20x21 multiplier: baseline times
//   percent, then divide by 100 as a reciprocal multiply, and for a channel
//   already blocked a further multiply by 90 and divide by 100.
//   A sample passes the multiply, divide and compare states (a blocked
//   channel also a scale and a second divide); its result is registered
//   as it leaves compare, and only then may the next sample transfer.
//   sample_stall is high while a sample is in work. A finished result
//   waits in the output register while the receiver stalls; the next
//   sample may transfer meanwhile and holds in compare until it is free.
//   Reset clears all blocked flags, baselines and trigger percents.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_beam_block_hysteresis
  import irbh_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [CH_W-1:0]     channel,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [CH_W-1:0]     channel_out,
  output logic                blocked,
  output logic [NUM_IR-1:0]   blocked_map
);

  localparam int ACTIVE = (CHANNELS < NUM_IR) ? CHANNELS : NUM_IR;
  localparam logic [CH_W:0] ACTIVE_LIM = (CH_W + 1)'(ACTIVE);
  localparam logic [CH_W-1:0] NUM_LIM  = CH_W'(NUM_IR);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULT  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [SAMPLE_W-1:0] base_mem [NUM_IR];
  logic [NUM_IR-1:0]   base_vld;
  logic [TRIGS_W-1:0]  trigger_percents;
  logic [NUM_IR-1:0]   flags;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic                scaled;
  logic                hold;
  logic [CH_W-1:0]     ch_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] base_q;
  logic [TRIG_W-1:0]   trig_q;
  logic [PROD_W-1:0]   acc;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [THR_W-1:0]    thr;
  logic [CMP_W-1:0]    need;
  logic                judge;
  logic                ch_ok;
  logic                now;
  logic                out_free;
  logic                sample_xfer;
  logic                cfg_wr;
  logic [REG_W-1:0]    wr_idx;
  logic [REG_W-1:0]    rd_idx;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign wr_idx      = paddr[ADDR_W-1:ADDR_W-REG_W];
  assign rd_idx      = paddr[ADDR_W-1:ADDR_W-REG_W];
  assign sample_stall = (state != S_IDLE);
  assign sample_xfer = sample_valid && !sample_stall;
  assign out_free    = !result_valid || !result_stall;

  // register file
  always_ff @(posedge clk) begin
    if (cfg_wr && wr_idx < NUM_LIM) begin
      base_mem[wr_idx] <= pwdata[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_vld         <= '0;
      trigger_percents <= '0;
    end else if (cfg_wr) begin
      if (wr_idx < NUM_LIM) begin
        base_vld[wr_idx] <= 1'b1;
      end else if (wr_idx == REG_TRIGGER) begin
        trigger_percents <= pwdata[TRIGS_W-1:0];
      end
    end
  end

  // capture read data in the setup cycle
  always_ff @(posedge clk) begin
    if (psel && !penable) begin
      if (rd_idx < NUM_LIM) begin
        prdata <= base_vld[rd_idx] ? DATA_W'(base_mem[rd_idx]) : '0;
      end else if (rd_idx == REG_TRIGGER) begin
        prdata <= DATA_W'(trigger_percents);
      end else begin
        prdata <= '0;
      end
    end
  end

  // latch the sample and its channel setup
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      ch_q     <= channel;
      sample_q <= sample;
      if (channel < NUM_LIM) begin
        base_q <= base_vld[channel] ? base_mem[channel] : '0;
        trig_q <= trigger_percents[channel*TRIG_W +: TRIG_W];
        hold   <= flags[channel];
      end else begin
        base_q <= '0;
        trig_q <= '0;
        hold   <= 1'b0;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_MULT: begin
        mul_a = MUL_A_W'(base_q);
        mul_b = MUL_B_W'(trig_q);
      end
      S_DIV: begin
        mul_a = acc[MUL_A_W-1:0];
        mul_b = DIV_RECIP;
      end
      S_SCALE: begin
        mul_a = MUL_A_W'(acc[PROD_W-1:DIV_SHIFT]);
        mul_b = HOLD_PERCENT;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state inside {S_MULT, S_DIV, S_SCALE}) begin
      acc <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // drop >= thr  <=>  base >= sample + thr
  assign thr   = acc[PROD_W-1:DIV_SHIFT];
  assign need  = CMP_W'(sample_q) + CMP_W'(thr);
  assign judge = CMP_W'(base_q) >= need;
  assign ch_ok = {1'b0, ch_q} < ACTIVE_LIM;
  assign now   = ch_ok && judge;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sample_xfer) begin
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        state_next = (hold && !scaled) ? S_SCALE : S_CMP;
      end
      S_SCALE: begin
        state_next = S_DIV;
      end
      S_CMP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      scaled <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCALE) begin
        scaled <= 1'b1;
      end else if (state == S_IDLE) begin
        scaled <= 1'b0;
      end
    end
  end

  // blocked flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      flags        <= '0;
      result_valid <= 1'b0;
    end else if (state == S_CMP && out_free) begin
      result_valid <= 1'b1;
      if (ch_ok) begin
        flags[ch_q] <= now;
      end
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CMP && out_free) begin
      channel_out <= ch_q;
      blocked     <= now;
      if (ch_ok) begin
        blocked_map <= (flags & ~(NUM_IR'(1) << ch_q)) | (NUM_IR'(now) << ch_q);
      end else begin
        blocked_map <= flags;
      end
    end
  end

  a_blocked_in_map : assert property (@(posedge clk) disable iff (rst)
    result_valid && blocked |-> ((blocked_map >> channel_out) & NUM_IR'(1)) != '0)
    else $error("blocked result without its bit in the map");

  a_map_active : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (blocked_map >> ACTIVE) == '0)
    else $error("map bit set for an inactive channel");

  a_result_from_cmp : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_CMP)
    else $error("result raised outside the compare step");

endmodule

// ===== tb/irbh_beam_checker.sv =====
// ---------------------------------------------------------------------------
// irbh_beam_checker - verdict checker for the IR beam-block detector
// Watches the register port and the sample and result channels, keeps its
// own copy of baselines, trigger percents and blocked flags, predicts the
// verdict of every accepted sample and compares each result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module irbh_beam_checker
  import irbh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                sample_valid,
  input  logic                sample_stall,
  input  logic [CH_W-1:0]     channel,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                result_valid,
  input  logic                result_stall,
  input  logic [CH_W-1:0]     channel_out,
  input  logic                blocked,
  input  logic [NUM_IR-1:0]   blocked_map,
  output int                  mismatches,
  output int                  pending
);

  localparam int PERCENT_FULL = 100;
  localparam int RELEASE_PCT  = 90;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic              blk;
    logic [NUM_IR-1:0] map;
  } beam_verdict_t;

  logic [SAMPLE_W-1:0] baseline [NUM_IR];
  logic [TRIGS_W-1:0]  trig_pack;
  logic [NUM_IR-1:0]   beam_flags;
  beam_verdict_t       verdict_q [$];
  beam_verdict_t       want;
  beam_verdict_t       fresh;
  int                  reg_idx;

  initial mismatches = 0;
  initial pending = 0;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic judge_beam(input logic [CH_W-1:0] ch,
                                      input logic [SAMPLE_W-1:0] smp);
    int base_lvl;
    int pct;
    int thr;
    int drop;
    base_lvl = int'(baseline[ch]);
    pct = int'(trig_pack[ch*TRIG_W +: TRIG_W]);
    thr = (base_lvl * pct) / PERCENT_FULL;
    if (beam_flags[ch]) begin
      thr = (thr * RELEASE_PCT) / PERCENT_FULL;
    end
    drop = base_lvl - int'(smp);
    return drop >= thr;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_IR; i++) begin
        baseline[i] = '0;
      end
      trig_pack = '0;
      beam_flags = '0;
      verdict_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_idx = int'(paddr) >> 3;
        if (reg_idx < NUM_IR) begin
          baseline[reg_idx] = pwdata[SAMPLE_W-1:0];
        end else if (reg_idx == int'(REG_TRIGGER)) begin
          trig_pack = pwdata[TRIGS_W-1:0];
        end
      end
      if (result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("result for channel %0d with none expected", channel_out));
        end else begin
          want = verdict_q.pop_front();
          if (channel_out !== want.ch) begin
            flag_mismatch($sformatf("channel_out %0d, expected %0d", channel_out, want.ch));
          end
          if (blocked !== want.blk) begin
            flag_mismatch($sformatf("blocked %0b on channel %0d, expected %0b",
                                    blocked, want.ch, want.blk));
          end
          if (blocked_map !== want.map) begin
            flag_mismatch($sformatf("blocked_map %b on channel %0d, expected %b",
                                    blocked_map, want.ch, want.map));
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        fresh.ch = channel;
        fresh.blk = 1'b0;
        if (int'(channel) < NUM_IR) begin
          fresh.blk = judge_beam(channel, sample);
          beam_flags[channel] = fresh.blk;
        end
        fresh.map = beam_flags;
        verdict_q.push_back(fresh);
      end
      pending <= verdict_q.size();
    end
  end

endmodule

// ===== tb/ir_beam_block_hysteresis_test.sv =====
// ---------------------------------------------------------------------------
// ir_beam_block_hysteresis_test - top of the beam-block detector testbench
// Programs baselines and trigger percents over the register port, sends a
// directed run of threshold and hysteresis corner cases, then phases of
// random samples, most aimed near each channel's threshold, with random gaps
// on the sample side and random stalls on the result side in some phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_beam_block_hysteresis_test;
  import irbh_pkg::*;

  localparam int PERCENT_FULL = 100;
  localparam int PHASES       = 6;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  logic [CH_W-1:0]     channel = '0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [CH_W-1:0]     channel_out;
  logic                blocked;
  logic [NUM_IR-1:0]   blocked_map;
  int                  mismatches;
  int                  pending;

  logic [SAMPLE_W-1:0] base_cfg [NUM_IR];
  logic [TRIG_W-1:0]   trig_cfg [NUM_IR];
  logic                tx_idle = 1'b1;
  logic                rx_idle = 1'b1;
  int                  rx_left = 0;

  ir_beam_block_hysteresis u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .channel      (channel),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .channel_out  (channel_out),
    .blocked      (blocked),
    .blocked_map  (blocked_map)
  );

  irbh_beam_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .channel      (channel),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .channel_out  (channel_out),
    .blocked      (blocked),
    .blocked_map  (blocked_map),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin : rx_side
    int n;
    if (rst) begin
      result_stall <= 1'b0;
      rx_left <= 0;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
      result_stall <= (rx_left > 1);
    end else if (result_valid && !result_stall) begin
      n = rx_idle ? $urandom_range(0, 7) : 0;
      rx_left <= n;
      result_stall <= (n > 0);
    end
  end

  task automatic apb_write(input int idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 8);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_all_regs();
    logic [DATA_W-1:0] packed_trig;
    packed_trig = '0;
    for (int i = 0; i < NUM_IR; i++) begin
      apb_write(i, DATA_W'(base_cfg[i]));
      packed_trig[i*TRIG_W +: TRIG_W] = trig_cfg[i];
    end
    apb_write(int'(REG_TRIGGER), packed_trig);
  endtask

  task automatic push_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    channel <= ch;
    sample <= smp;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic drain_results();
    int w;
    sample_valid <= 1'b0;
    w = 0;
    do begin
      @(posedge clk);
      w++;
    end while (pending != 0 && w < 4000);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int counts [PHASES];
    logic [CH_W-1:0] ch;
    logic [SAMPLE_W-1:0] smp;
    int thr;
    int tgt;

    counts = '{110, 40, 40, 120, 120, 120};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    base_cfg = '{12'd0, 12'd4095, 12'd2048, 12'd1000, 12'd4095, 12'd1};
    trig_cfg = '{8'd0, 8'd255, 8'd100, 8'd50, 8'd1, 8'd200};
    write_all_regs();

    push_sample(3'd0, 12'd0);
    push_sample(3'd0, 12'd5);
    push_sample(3'd0, 12'd0);
    push_sample(3'd1, 12'd0);
    push_sample(3'd1, 12'd4095);
    push_sample(3'd2, 12'd0);
    push_sample(3'd2, 12'd4095);
    push_sample(3'd3, 12'd500);
    push_sample(3'd3, 12'd550);
    push_sample(3'd3, 12'd551);
    push_sample(3'd3, 12'd501);
    push_sample(3'd4, 12'd4055);
    push_sample(3'd4, 12'd4058);
    push_sample(3'd4, 12'd4059);
    push_sample(3'd4, 12'd4060);
    push_sample(3'd5, 12'd0);
    push_sample(3'd6, 12'd0);
    push_sample(3'd7, 12'd4095);
    push_sample(3'd5, 12'd4095);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < NUM_IR; i++) begin
        case (p)
          1: begin
            base_cfg[i] = 12'd4095;
            trig_cfg[i] = 8'd255;
          end
          2: begin
            base_cfg[i] = 12'd0;
            trig_cfg[i] = 8'd0;
          end
          3: begin
            base_cfg[i] = SAMPLE_W'($urandom_range(0, 4095));
            trig_cfg[i] = TRIG_W'($urandom_range(5, 40));
          end
          default: begin
            base_cfg[i] = SAMPLE_W'($urandom_range(0, 4095));
            trig_cfg[i] = TRIG_W'($urandom_range(0, 255));
          end
        endcase
      end
      write_all_regs();
      tx_idle = (p % 3 != 1) ? ($urandom_range(0, 3) != 0) : 1'b0;
      rx_idle = (p % 3 != 1) ? ($urandom_range(0, 3) != 0) : 1'b0;

      for (int k = 0; k < counts[p]; k++) begin
        if ($urandom_range(0, 15) == 0) begin
          ch = CH_W'($urandom_range(NUM_IR, 7));
        end else begin
          ch = CH_W'($urandom_range(0, NUM_IR - 1));
        end
        if (int'(ch) < NUM_IR && $urandom_range(0, 9) < 6) begin
          thr = int'(base_cfg[ch]) * int'(trig_cfg[ch]) / PERCENT_FULL;
          tgt = int'(base_cfg[ch]) - thr + $urandom_range(0, 120) - 60;
          if (tgt < 0) begin
            tgt = 0;
          end
          if (tgt > 4095) begin
            tgt = 4095;
          end
          smp = SAMPLE_W'(tgt);
        end else begin
          smp = SAMPLE_W'($urandom_range(0, 4095));
        end
        push_sample(ch, smp);
      end
      drain_results();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
